@@ hw/rtl/erp_pkg.sv @@
package erp_pkg;

  // Fixed field widths.
  localparam int unsigned PtrW       = 13;
  localparam int unsigned SpacingW   = 16;
  localparam int unsigned InTdataW   = 32;
  localparam logic [SpacingW-1:0] SpacingRst = 16'd2560;

  // Operating modes of the shared iterative unit.
  localparam logic ModeSqrt = 1'b0;
  localparam logic ModeDiv  = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } erp_cmd_t;

endpackage

@@ hw/rtl/equidistant_path_resampler.sv @@
// Channel  | Direction | Word
// s_axis   | in        | tdata: pointer_x, pointer_y; tuser: action
// m_axis   | out       | tdata: point_x, point_y; tuser: is_start; tlast: last_of_run
// cfg      | in        | data: spacing
//
// A start item (restart, or no path yet) goes straight to the output state and waits there for m_axis.
// An extend item runs, per emitted point, the bit-serial root and the two bit-serial
// divides in the shared unit; the root gives MW = 14 + FRACTION_BITS bits and each
// divide NW = MW + 17 quotient bits.
// s_axis_tready_o is high only while no item is in work; a stalled m_axis holds the
// sequencer in place. Reset clears the anchor and the open-path flag and restores the
// default spacing.
module equidistant_path_resampler #(
  parameter int unsigned MAX_STEPS_PER_ITEM = 64,
  parameter int unsigned FRACTION_BITS      = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [erp_pkg::InTdataW-1:0] s_axis_tdata_i,  // pointer_x, pointer_y
  input  logic                 s_axis_tuser_i,          // action
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [((2*(13+FRACTION_BITS)+7)/8)*8-1:0] m_axis_tdata_o,  // point_x, point_y
  output logic                 m_axis_tuser_o,          // is_start
  output logic                 m_axis_tlast_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [erp_pkg::SpacingW-1:0] cfg_data_i
);
  import erp_pkg::*;

  localparam int unsigned CW   = PtrW + FRACTION_BITS;
  localparam int unsigned MW   = CW + 1;
  localparam int unsigned D2W  = 2 * MW;
  localparam int unsigned NW   = MW + SpacingW + 1;
  localparam int unsigned OutW = ((2 * CW + 7) / 8) * 8;
  localparam int unsigned NCW  = $clog2(MAX_STEPS_PER_ITEM + 1);

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StS2Mul  = 5'd1;
  localparam logic [4:0] StS2Save = 5'd2;
  localparam logic [4:0] StDiff   = 5'd3;
  localparam logic [4:0] StMx     = 5'd4;
  localparam logic [4:0] StMy     = 5'd5;
  localparam logic [4:0] StCmp    = 5'd6;
  localparam logic [4:0] StOut    = 5'd7;
  localparam logic [4:0] StSqGo   = 5'd8;
  localparam logic [4:0] StSqWait = 5'd9;
  localparam logic [4:0] StMulX   = 5'd10;
  localparam logic [4:0] StDxGo   = 5'd11;
  localparam logic [4:0] StDxWait = 5'd12;
  localparam logic [4:0] StMulY   = 5'd13;
  localparam logic [4:0] StDyGo   = 5'd14;
  localparam logic [4:0] StDyWait = 5'd15;
  localparam logic [4:0] StUpd    = 5'd16;

  logic [4:0] state_q, state_d;

  logic [SpacingW-1:0] spacing_q;
  logic [SpacingW-1:0] s_q;
  logic [D2W-1:0]      s2_q;
  logic signed [CW-1:0] px_q, py_q;
  logic signed [CW-1:0] anchor_x_q, anchor_y_q;
  logic                path_open_q;
  logic signed [CW:0]  dx_q, dy_q;
  logic [MW-1:0]       ax_q, ay_q;
  logic [D2W-1:0]      acc_q, d2_q, prod_q;
  logic [MW-1:0]       dist_q, qx_q;
  logic [NCW-1:0]      n_q;
  logic                start_q, last_q;

  logic [OutW-1:0]     out_data_q;
  logic                out_valid_q, out_start_q, out_last_q;

  logic [MW-1:0]       mul_a, mul_b;
  logic [D2W-1:0]      prod_d;
  logic [D2W-1:0]      d2_sum;
  logic signed [CW:0]  dx_c, dy_c;
  erp_cmd_t            cmd;
  logic [D2W-1:0]      unit_a;
  logic                unit_done;
  logic [D2W-1:0]      unit_res;
  logic                out_free;
  logic signed [CW-1:0] sat_x, sat_y;

  function automatic logic signed [CW-1:0] sat_add(input logic signed [CW-1:0] base,
                                                   input logic [MW-1:0] mag,
                                                   input logic neg);
    logic signed [CW+1:0] step;
    logic signed [CW+1:0] sum;
    step = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sum  = $signed({{2{base[CW-1]}}, base}) + step;
    if (sum[CW+1:CW-1] == 3'b000 || sum[CW+1:CW-1] == 3'b111) begin
      sat_add = sum[CW-1:0];
    end else if (sum[CW+1]) begin
      sat_add = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_add = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle);

  assign dx_c   = $signed({px_q[CW-1], px_q}) - $signed({anchor_x_q[CW-1], anchor_x_q});
  assign dy_c   = $signed({py_q[CW-1], py_q}) - $signed({anchor_y_q[CW-1], anchor_y_q});
  assign d2_sum = acc_q + prod_q;
  assign sat_x  = sat_add(anchor_x_q, qx_q, dx_q[CW]);
  assign sat_y  = sat_add(anchor_y_q, unit_res[MW-1:0], dy_q[CW]);

  // The one multiplier: spacing squared, the squared offsets and offset times spacing.
  always_comb begin
    unique case (state_q)
      StS2Mul: begin
        mul_a = MW'(s_q);
        mul_b = MW'(s_q);
      end
      StMx: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      StMy: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      StMulX: begin
        mul_a = ax_q;
        mul_b = MW'(s_q);
      end
      StMulY: begin
        mul_a = ay_q;
        mul_b = MW'(s_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    cmd.start = (state_q == StSqGo) || (state_q == StDxGo) || (state_q == StDyGo);
    cmd.mode  = (state_q == StSqGo) ? ModeSqrt : ModeDiv;
    // Adding half the distance rounds the quotient to nearest, ties away from zero.
    unit_a    = (state_q == StSqGo) ? d2_q : prod_q + D2W'(dist_q >> 1);
  end

  erp_iter_unit #(
    .MW (MW),
    .D2W(D2W),
    .NW (NW)
  ) u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .op_a_i  (unit_a),
    .op_b_i  (dist_q),
    .done_o  (unit_done),
    .result_o(unit_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i || !path_open_q) begin
            state_d = StOut;
          end else begin
            state_d = StS2Mul;
          end
        end
      end
      StS2Mul:  state_d = StS2Save;
      StS2Save: state_d = StDiff;
      StDiff:   state_d = StMx;
      StMx:     state_d = StMy;
      StMy:     state_d = StCmp;
      StCmp: begin
        if (d2_sum < s2_q) begin
          state_d = (n_q != '0) ? StOut : StIdle;
        end else begin
          state_d = (n_q != '0) ? StOut : StSqGo;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = last_q ? StIdle : StSqGo;
        end
      end
      StSqGo:   state_d = StSqWait;
      StSqWait: state_d = unit_done ? StMulX : StSqWait;
      StMulX:   state_d = StDxGo;
      StDxGo:   state_d = StDxWait;
      StDxWait: state_d = unit_done ? StMulY : StDxWait;
      StMulY:   state_d = StDyGo;
      StDyGo:   state_d = StDyWait;
      StDyWait: state_d = unit_done ? StUpd : StDyWait;
      StUpd: begin
        state_d = (NCW'(n_q + 1'b1) == NCW'(MAX_STEPS_PER_ITEM)) ? StOut : StDiff;
      end
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      spacing_q   <= SpacingRst;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      path_open_q <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      start_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        spacing_q <= cfg_data_i;
      end
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          n_q <= '0;
          if (s_axis_tvalid_i && (s_axis_tuser_i || !path_open_q)) begin
            anchor_x_q  <= {s_axis_tdata_i[PtrW-1:0], {FRACTION_BITS{1'b0}}};
            anchor_y_q  <= {s_axis_tdata_i[2*PtrW-1:PtrW], {FRACTION_BITS{1'b0}}};
            path_open_q <= 1'b1;
            start_q     <= 1'b1;
            last_q      <= 1'b1;
          end
        end
        StCmp: begin
          start_q <= 1'b0;
          last_q  <= (d2_sum < s2_q);
        end
        StUpd: begin
          anchor_x_q <= sat_x;
          anchor_y_q <= sat_y;
          n_q        <= n_q + 1'b1;
          start_q    <= 1'b0;
          last_q     <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == StIdle && s_axis_tvalid_i) begin
      px_q <= {s_axis_tdata_i[PtrW-1:0], {FRACTION_BITS{1'b0}}};
      py_q <= {s_axis_tdata_i[2*PtrW-1:PtrW], {FRACTION_BITS{1'b0}}};
      s_q  <= (spacing_q == '0) ? SpacingW'(1) : spacing_q;
    end
    if (state_q == StS2Save) begin
      s2_q <= prod_q;
    end
    if (state_q == StDiff) begin
      dx_q <= dx_c;
      dy_q <= dy_c;
      ax_q <= dx_c[CW] ? MW'(-dx_c) : MW'(dx_c);
      ay_q <= dy_c[CW] ? MW'(-dy_c) : MW'(dy_c);
    end
    if (state_q == StMy) begin
      acc_q <= prod_q;
    end
    if (state_q == StCmp) begin
      d2_q <= d2_sum;
    end
    if (state_q == StSqWait && unit_done) begin
      dist_q <= unit_res[MW-1:0];
    end
    if (state_q == StDxWait && unit_done) begin
      qx_q <= unit_res[MW-1:0];
    end
    if (state_q == StOut && out_free) begin
      out_data_q  <= OutW'({anchor_y_q, anchor_x_q});
      out_start_q <= start_q;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_start_q;
  assign m_axis_tlast_o  = out_last_q;

  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NCW'(MAX_STEPS_PER_ITEM))
    else $error("step count beyond cap");

  a_start_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("start point not marked last");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == StSqWait || state_q == StDxWait || state_q == StDyWait))
    else $error("shared unit finished outside a wait state");

endmodule

@@ hw/rtl/erp_iter_unit.sv @@
module erp_iter_unit #(
  parameter int unsigned MW  = 22,
  parameter int unsigned D2W = 44,
  parameter int unsigned NW  = 39
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  erp_pkg::erp_cmd_t cmd_i,
  input  logic [D2W-1:0]    op_a_i,
  input  logic [MW-1:0]     op_b_i,
  output logic              done_o,
  output logic [D2W-1:0]    result_o
);
  import erp_pkg::*;

  localparam int unsigned CntW = $clog2(D2W + 1);
  localparam int unsigned Align = D2W - NW;

  logic [D2W-1:0] opnd_q;
  logic [MW-1:0]  div_q;
  logic [MW+1:0]  rem_q;
  logic [D2W-1:0] res_q;
  logic [CntW-1:0] cnt_q;
  logic           busy_q;
  logic           mode_q;
  logic           done_q;

  logic [MW+1:0]  rem_shift;
  logic [MW+1:0]  trial;
  logic [MW+2:0]  diff;
  logic           fits;

  // One root bit (two operand bits) or one quotient bit (one operand bit) per cycle,
  // both through the same subtractor.
  always_comb begin
    if (mode_q == ModeSqrt) begin
      rem_shift = {rem_q[MW-1:0], opnd_q[D2W-1 -: 2]};
      trial     = {res_q[MW-1:0], 2'b01};
    end else begin
      rem_shift = {rem_q[MW:0], opnd_q[D2W-1]};
      trial     = {2'b00, div_q};
    end
    diff = {1'b0, rem_shift} - {1'b0, trial};
    fits = ~diff[MW+2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= ModeSqrt;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        mode_q <= cmd_i.mode;
        cnt_q  <= (cmd_i.mode == ModeSqrt) ? CntW'(MW) : CntW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      opnd_q <= (cmd_i.mode == ModeDiv) ? (op_a_i << Align) : op_a_i;
      div_q  <= op_b_i;
      rem_q  <= '0;
      res_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[MW+1:0] : rem_shift;
      res_q  <= {res_q[D2W-2:0], fits};
      opnd_q <= (mode_q == ModeSqrt) ? (opnd_q << 2) : (opnd_q << 1);
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
